// ===== hw/rtl/aavtc_pkg.sv =====
// Shared types and constants for the averaging / reference-compensated converter.
// Used by aavtc_front, aavtc_back and the top level; depends on nothing.
package aavtc_pkg;

	// Field widths
	localparam int SampleW = 12;
	localparam int SumW    = 16;
	localparam int AvgW    = 16;
	localparam int MvW     = 16;
	localparam int TempW   = 16;
	localparam int RefOutW = 12;
	localparam int ScaleW  = 32;
	localparam int CalW    = 12;
	localparam int CfgIdxW = 2;
	localparam int NumCh   = 4;
	localparam int ChW     = 2;

	// Arithmetic widths
	localparam int MulW      = 32;
	localparam int ProdW     = 2 * MulW;
	localparam int RecipShift = 24;
	localparam int DivNW     = 40;
	localparam int DivDW     = 28;
	localparam int DiffW     = DivDW + 1;
	localparam int NumW      = DivNW + 1;

	// Temperature formula constants
	localparam int TempScale  = 1000;
	localparam int TempOffset = 300;

	localparam logic [ScaleW-1:0] ScaleReset = 32'd78902463;

	// Channel slots
	localparam logic [ChW-1:0] CH_GPS  = 2'd0;
	localparam logic [ChW-1:0] CH_BAT  = 2'd1;
	localparam logic [ChW-1:0] CH_TEMP = 2'd2;
	localparam logic [ChW-1:0] CH_REF  = 2'd3;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_SUPPLY_SCALE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_REF_CAL      = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CAL_LOW      = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CAL_HIGH     = 2'd3;

	typedef logic [NumCh-1:0][SampleW-1:0] raw_set_t;
	typedef logic [NumCh-1:0][SumW-1:0]    sums_t;

	typedef struct packed {
		logic [ScaleW-1:0] supply_scale;
		logic [CalW-1:0]   ref_cal;
		logic [CalW-1:0]   cal_low;
		logic [CalW-1:0]   cal_high;
	} cfg_t;

	typedef struct packed {
		logic [MvW-1:0]     gps_mv;
		logic [MvW-1:0]     bat_mv;
		logic [TempW-1:0]   temp;
		logic [RefOutW-1:0] ref_avg;
		logic               err;
	} result_t;

endpackage

// ===== hw/rtl/aavtc_fifo.sv =====
// Small register-based queue, used between front and back and on the result side.
// Standalone; no package dependency.
module aavtc_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CntW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// store incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/aavtc_front.sv =====
// Front end: accumulates sample sets per channel and emits the sums of each full batch.
// Depends on aavtc_pkg.
module aavtc_front
	import aavtc_pkg::*;
#(
	parameter int ITERATIONS  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  raw_set_t raw,
	output logic     batch_push,
	output sums_t    batch_sums
);
	localparam int CountW = $clog2(ITERATIONS + 1);
	localparam logic [SampleW-1:0] SampleMask =
		(SAMPLE_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);

	logic [CountW-1:0] count_q;
	sums_t             sums_q;
	sums_t             sums_nxt;
	logic              last;

	// add masked samples, wrapping at the sum width
	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			sums_nxt[ch] = sums_q[ch] + SumW'(raw[ch] & SampleMask);
		end
	end

	assign last       = (count_q == CountW'(ITERATIONS - 1));
	assign batch_push = item_valid & last;
	assign batch_sums = sums_nxt;

	// hold running sums; clear after the closing set of a batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sums_q  <= '0;
		end else if (item_valid) begin
			if (last) begin
				count_q <= '0;
				sums_q  <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sums_q  <= sums_nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/aavtc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package dependency.
module aavtc_div #(
	parameter int DIVIDEND_W = 40,
	parameter int DIVISOR_W  = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic                  done
);
	localparam int CntW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CntW-1:0]       cnt_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = ~trial[DIVISOR_W];

	assign quotient = quo_q;
	assign done     = done_q;

	// datapath: load on start, then shift one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(DIVIDEND_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CntW'(1));
			end
		end
	end

endmodule

// ===== hw/rtl/aavtc_back.sv =====
// Back end: turns batch sums into averages, compensated voltages and die temperature.
// Depends on aavtc_pkg and aavtc_div.
module aavtc_back
	import aavtc_pkg::*;
#(
	parameter int ITERATIONS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    batch_empty,
	input  sums_t   batch_sums,
	output logic    batch_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res_data
);
	localparam int RecipScale = ((1 << RecipShift) + ITERATIONS - 1) / ITERATIONS;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_AVG    = 10'b0000000010,
		ST_VMUL   = 10'b0000000100,
		ST_VDIV   = 10'b0000001000,
		ST_TMUL   = 10'b0000010000,
		ST_TSCALE = 10'b0000100000,
		ST_TOFS   = 10'b0001000000,
		ST_TSTART = 10'b0010000000,
		ST_TDIV   = 10'b0100000000,
		ST_EMIT   = 10'b1000000000
	} state_t;

	state_t                          state_q;
	logic [ChW-1:0]                  ch_q;
	sums_t                           sums_q;
	logic [NumCh-1:0][AvgW-1:0]      avg_q;
	logic [MvW-1:0]                  gps_mv_q, bat_mv_q;
	logic [TempW-1:0]                temp_q;
	logic                            err_q;
	logic [DivDW-1:0]                n_q;
	logic signed [DiffW-1:0]         diff_q;
	logic [DivDW-1:0]                den_mag_q;
	logic signed [NumW-1:0]          num_q;

	logic [MulW-1:0]                 mul_a, mul_b;
	logic [ProdW-1:0]                prod;
	logic                            span_neg, span_zero;
	logic [CalW-1:0]                 span_mag;
	logic signed [NumW-1:0]          diff_ext, den_ext, den_pos;
	logic [NumW-1:0]                 num_abs;
	logic                            ref_zero;
	logic                            div_start;
	logic [DivNW-1:0]                div_dividend, div_quot;
	logic [DivDW-1:0]                div_divisor;
	logic                            div_done;
	logic                            tneg;
	logic [MvW-1:0]                  volt_sat;
	logic [TempW-1:0]                temp_sat;

	// calibration span
	assign span_neg  = cfg.cal_low > cfg.cal_high;
	assign span_mag  = span_neg ? (cfg.cal_low - cfg.cal_high) : (cfg.cal_high - cfg.cal_low);
	assign span_zero = (cfg.cal_high == cfg.cal_low);
	assign ref_zero  = (avg_q[CH_REF] == '0);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_AVG: begin
				mul_a = MulW'(sums_q[ch_q]);
				mul_b = MulW'(RecipScale);
			end
			ST_VMUL: begin
				mul_a = MulW'(avg_q[ch_q]);
				mul_b = cfg.supply_scale;
			end
			ST_TMUL: begin
				case (ch_q)
					2'd0: begin
						mul_a = MulW'(avg_q[CH_TEMP]);
						mul_b = MulW'(cfg.ref_cal);
					end
					2'd1: begin
						mul_a = MulW'(cfg.cal_low);
						mul_b = MulW'(avg_q[CH_REF]);
					end
					default: begin
						mul_a = MulW'(avg_q[CH_REF]);
						mul_b = MulW'(span_mag);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = ProdW'(mul_a) * ProdW'(mul_b);

	// signed numerator terms
	assign diff_ext = {{(NumW - DiffW){diff_q[DiffW-1]}}, diff_q};
	assign den_pos  = $signed({{(NumW - DivDW){1'b0}}, den_mag_q});
	assign den_ext  = span_neg ? -den_pos : den_pos;
	assign num_abs  = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

	// divider feed
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_VMUL: begin
				div_start    = ~ref_zero;
				div_dividend = DivNW'(prod[ProdW-1-16:16]);
				div_divisor  = DivDW'(avg_q[CH_REF]);
			end
			ST_TSTART: begin
				div_start    = 1'b1;
				div_dividend = num_abs[DivNW-1:0];
				div_divisor  = den_mag_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	aavtc_div #(
		.DIVIDEND_W(DivNW),
		.DIVISOR_W (DivDW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quot),
		.done    (div_done)
	);

	// saturate quotients
	assign volt_sat = (div_quot[DivNW-1:MvW] != '0) ? {MvW{1'b1}} : div_quot[MvW-1:0];
	assign tneg     = num_q[NumW-1] ^ span_neg;
	always_comb begin
		if (tneg) begin
			temp_sat = (div_quot > DivNW'(32768)) ? 16'h8000 : TempW'(~div_quot[TempW-1:0] + 1'b1);
		end else begin
			temp_sat = (div_quot > DivNW'(32767)) ? 16'h7fff : div_quot[TempW-1:0];
		end
	end

	assign batch_pop        = (state_q == ST_IDLE) & ~batch_empty;
	assign res_push         = (state_q == ST_EMIT) & ~res_full;
	assign res_data.gps_mv  = gps_mv_q;
	assign res_data.bat_mv  = bat_mv_q;
	assign res_data.temp    = temp_q;
	assign res_data.ref_avg = avg_q[CH_REF][RefOutW-1:0];
	assign res_data.err     = err_q;

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sums_q <= batch_sums;
			end
			ST_AVG: begin
				avg_q[ch_q] <= prod[RecipShift+AvgW-1:RecipShift];
			end
			ST_TMUL: begin
				case (ch_q)
					2'd0:    n_q <= prod[DivDW-1:0];
					2'd1:    diff_q <= $signed({1'b0, n_q}) - $signed({1'b0, prod[DivDW-1:0]});
					default: den_mag_q <= prod[DivDW-1:0];
				endcase
			end
			ST_TSCALE: begin
				num_q <= diff_ext * $signed(NumW'(TempScale));
			end
			ST_TOFS: begin
				num_q <= num_q + den_ext * $signed(NumW'(TempOffset));
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ch_q     <= '0;
			gps_mv_q <= '0;
			bat_mv_q <= '0;
			temp_q   <= '0;
			err_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!batch_empty) begin
						ch_q     <= '0;
						gps_mv_q <= '0;
						bat_mv_q <= '0;
						temp_q   <= '0;
						err_q    <= 1'b0;
						state_q  <= ST_AVG;
					end
				end
				ST_AVG: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == CH_REF) begin
						state_q <= ST_VMUL;
					end
				end
				ST_VMUL: begin
					if (ref_zero) begin
						err_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (div_done) begin
						if (ch_q == CH_GPS) begin
							gps_mv_q <= volt_sat;
							ch_q     <= CH_BAT;
							state_q  <= ST_VMUL;
						end else begin
							bat_mv_q <= volt_sat;
							ch_q     <= '0;
							if (span_zero) begin
								err_q   <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_TMUL;
							end
						end
					end
				end
				ST_TMUL: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == 2'd2) begin
						state_q <= ST_TSCALE;
					end
				end
				ST_TSCALE: begin
					state_q <= ST_TOFS;
				end
				ST_TOFS: begin
					state_q <= ST_TSTART;
				end
				ST_TSTART: begin
					state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					if (div_done) begin
						temp_q  <= temp_sat;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/adc_average_vref_temp_convert.sv =====
// Top level: configuration registers, front accumulator, batch queue, back converter,
// result queue. Depends on aavtc_pkg, aavtc_fifo, aavtc_front, aavtc_back.
//
// Usage:
//   Input side is a queue: drive the four raw samples and raise push; a word is taken
//   at a clock edge with push high and full low. The front takes one word per cycle
//   while full is low. Every ITERATIONS words close a batch whose sums enter a
//   two-entry queue. Result side is a queue: while empty is low the oldest result
//   is on the result ports; it leaves at a clock edge with pop high. One result per
//   batch. The back converts one batch at a time with its serial divider, three
//   quotients: two voltages, temperature. A zero calibration span ends the batch
//   after the voltages, a zero reference average before any quotient; both set
//   divide_error.
//   If results are not popped, two results wait in the output queue, the back holds a
//   third, then the batch queue fills and full rises; nothing is dropped.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while the block holds no unfinished batch.
//   Reset clears sums, counters, queues and loads the register defaults.
module adc_average_vref_temp_convert
	import aavtc_pkg::*;
#(
	parameter int ITERATIONS  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [SampleW-1:0]    raw_gps_rail,
	input  logic [SampleW-1:0]    raw_battery,
	input  logic [SampleW-1:0]    raw_die_temp,
	input  logic [SampleW-1:0]    raw_reference,
	output logic                  empty,
	input  logic                  pop,
	output logic [MvW-1:0]        gps_rail_mv,
	output logic [MvW-1:0]        battery_mv,
	output logic signed [TempW-1:0] die_temp_tenths,
	output logic [RefOutW-1:0]    reference_average,
	output logic                  divide_error,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [ScaleW-1:0]     cfg_data
);
	cfg_t     cfg_q;
	raw_set_t raw;
	logic     item_valid;
	logic     batch_push, batch_full, batch_empty, batch_pop;
	sums_t    batch_in, batch_out;
	logic     res_push, res_full;
	result_t  res_in, res_out;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.supply_scale <= ScaleReset;
			cfg_q.ref_cal      <= '0;
			cfg_q.cal_low      <= '0;
			cfg_q.cal_high     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SUPPLY_SCALE: cfg_q.supply_scale <= cfg_data;
				REG_REF_CAL:      cfg_q.ref_cal      <= cfg_data[CalW-1:0];
				REG_CAL_LOW:      cfg_q.cal_low      <= cfg_data[CalW-1:0];
				REG_CAL_HIGH:     cfg_q.cal_high     <= cfg_data[CalW-1:0];
				default: begin
				end
			endcase
		end
	end

	// gather one word of samples
	assign raw[CH_GPS]  = raw_gps_rail;
	assign raw[CH_BAT]  = raw_battery;
	assign raw[CH_TEMP] = raw_die_temp;
	assign raw[CH_REF]  = raw_reference;
	assign full         = batch_full;
	assign item_valid   = push & ~batch_full;

	aavtc_front #(
		.ITERATIONS (ITERATIONS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.raw       (raw),
		.batch_push(batch_push),
		.batch_sums(batch_in)
	);

	aavtc_fifo #(
		.WIDTH($bits(sums_t)),
		.DEPTH(2)
	) u_batch_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (batch_push),
		.wdata (batch_in),
		.full  (batch_full),
		.pop   (batch_pop),
		.rdata (batch_out),
		.empty (batch_empty)
	);

	aavtc_back #(
		.ITERATIONS(ITERATIONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.batch_empty(batch_empty),
		.batch_sums (batch_out),
		.batch_pop  (batch_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	aavtc_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	// present the oldest result
	assign gps_rail_mv       = res_out.gps_mv;
	assign battery_mv        = res_out.bat_mv;
	assign die_temp_tenths   = res_out.temp;
	assign reference_average = res_out.ref_avg;
	assign divide_error      = res_out.err;

endmodule
